// ===== sv/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and constants for the integer to Roman numeral block
// Character codes, the run of characters handed to the emitter, and sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2r_pkg;

    localparam int VALUE_W   = 12;
    localparam int CHAR_W    = 7;
    localparam int RUN_SLOTS = 15;
    localparam int LEN_W     = 4;

    typedef logic [VALUE_W-1:0]          value_t;
    typedef logic [CHAR_W-1:0]           char_t;
    typedef logic [RUN_SLOTS*CHAR_W-1:0] run_chars_t;
    typedef logic [LEN_W-1:0]            run_len_t;

    // Slot 0 (the first character out) sits in the top bits of chars.
    typedef struct packed {
        run_chars_t chars;
        run_len_t   len;
        logic       err;
    } run_t;

    localparam char_t CH_NUL = 7'h00;
    localparam char_t CH_I   = 7'h49;
    localparam char_t CH_V   = 7'h56;
    localparam char_t CH_X   = 7'h58;
    localparam char_t CH_L   = 7'h4C;
    localparam char_t CH_C   = 7'h43;
    localparam char_t CH_D   = 7'h44;
    localparam char_t CH_M   = 7'h4D;

    localparam value_t MAX_VALUE = 12'd3999;

endpackage

// ===== sv/integer_to_roman_numeral.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral: converts 1..3999 to Roman numeral characters
// Each value passes stages 1 to 4 and then loads into the emitter, which sends
// its numeral (1..15 characters) one character per cycle while char_stall is
// low; the four pipeline stages buffer further inputs meanwhile.
// Reset clears all valid bits; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_roman_numeral (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  i2r_pkg::value_t value,
    output logic            char_valid,
    input  logic            char_stall,
    output i2r_pkg::char_t  symbol_char,
    output logic            last_char,
    output logic            range_error
);
    import i2r_pkg::*;

    localparam int DIGIT_SLOTS = 4;
    localparam int PAIR_SLOTS  = 2 * DIGIT_SLOTS;

    typedef struct packed {
        logic [DIGIT_SLOTS*CHAR_W-1:0] chars;
        logic [2:0]                    len;
    } digit_pat_t;

    typedef struct packed {
        logic [PAIR_SLOTS*CHAR_W-1:0] chars;
        logic [3:0]                   len;
    } pair_t;

    function automatic logic [3:0] lead_digit(input logic [9:0] r, input logic [9:0] unit);
        logic [3:0] d;
        d = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (r >= 10'(k) * unit)
                d = 4'(k);
        end
        return d;
    endfunction

    function automatic digit_pat_t digit_pattern(input logic [3:0] d, input char_t one,
                                                 input char_t five, input char_t ten);
        digit_pat_t p;
        p.chars = '0;
        p.len   = '0;
        case (d)
            4'd1: begin p.chars = {one, CH_NUL, CH_NUL, CH_NUL};  p.len = 3'd1; end
            4'd2: begin p.chars = {one, one, CH_NUL, CH_NUL};     p.len = 3'd2; end
            4'd3: begin p.chars = {one, one, one, CH_NUL};        p.len = 3'd3; end
            4'd4: begin p.chars = {one, five, CH_NUL, CH_NUL};    p.len = 3'd2; end
            4'd5: begin p.chars = {five, CH_NUL, CH_NUL, CH_NUL}; p.len = 3'd1; end
            4'd6: begin p.chars = {five, one, CH_NUL, CH_NUL};    p.len = 3'd2; end
            4'd7: begin p.chars = {five, one, one, CH_NUL};       p.len = 3'd3; end
            4'd8: begin p.chars = {five, one, one, one};          p.len = 3'd4; end
            4'd9: begin p.chars = {one, ten, CH_NUL, CH_NUL};     p.len = 3'd2; end
            default: begin p.chars = '0; p.len = '0; end
        endcase
        return p;
    endfunction

    function automatic pair_t join_pair(input digit_pat_t a, input digit_pat_t b);
        pair_t p;
        p.chars = {a.chars, {(DIGIT_SLOTS*CHAR_W){1'b0}}}
                | ({b.chars, {(DIGIT_SLOTS*CHAR_W){1'b0}}} >> (CHAR_W * a.len));
        p.len   = 4'(a.len) + 4'(b.len);
        return p;
    endfunction

    // Stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic load_ready;

    // Stage 1: range check and thousands digit
    logic       err1_reg, err1_next;
    logic [1:0] thou1_reg, thou1_next;
    logic [9:0] rem1_reg, rem1_next;

    // Stage 2: hundreds digit
    logic       err2_reg;
    logic [1:0] thou2_reg;
    logic [3:0] hund2_reg, hund2_next;
    logic [6:0] rem2_reg, rem2_next;

    // Stage 3: tens and ones digits
    logic       err3_reg;
    logic [1:0] thou3_reg;
    logic [3:0] hund3_reg, tens3_reg, tens3_next, ones3_reg, ones3_next;

    // Stage 4: digit letters packed in pairs
    logic  err4_reg;
    pair_t hi4_reg, hi4_next, lo4_reg, lo4_next;

    logic [2*PAIR_SLOTS*CHAR_W-1:0] run_wide;
    run_t                           load_run;

    assign en4 = !v4_reg || load_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign item_stall = !en1;

    always_comb
    begin
        err1_next = (value == '0) || (value > MAX_VALUE);
        if (value >= 12'd3000)
            thou1_next = 2'd3;
        else if (value >= 12'd2000)
            thou1_next = 2'd2;
        else if (value >= 12'd1000)
            thou1_next = 2'd1;
        else
            thou1_next = 2'd0;
        rem1_next  = 10'(value - 12'(thou1_next) * 12'd1000);

        hund2_next = lead_digit(rem1_reg, 10'd100);
        rem2_next  = 7'(rem1_reg - 10'(hund2_next) * 10'd100);

        tens3_next = lead_digit(10'(rem2_reg), 10'd10);
        ones3_next = 4'(rem2_reg - 7'(tens3_next) * 7'd10);

        hi4_next = join_pair(digit_pattern(4'(thou3_reg), CH_M, CH_NUL, CH_NUL),
                             digit_pattern(hund3_reg, CH_C, CH_D, CH_M));
        lo4_next = join_pair(digit_pattern(tens3_reg, CH_X, CH_L, CH_C),
                             digit_pattern(ones3_reg, CH_I, CH_V, CH_X));
    end

    // Final join: the lower pair lands right after the upper pair's letters
    always_comb
    begin
        run_wide = {hi4_reg.chars, {(PAIR_SLOTS*CHAR_W){1'b0}}}
                 | ({lo4_reg.chars, {(PAIR_SLOTS*CHAR_W){1'b0}}} >> (CHAR_W * hi4_reg.len));
        if (err4_reg)
        begin
            load_run.chars = '0;
            load_run.len   = run_len_t'(1);
            load_run.err   = 1'b1;
        end
        else
        begin
            load_run.chars = run_wide[2*PAIR_SLOTS*CHAR_W-1 -: RUN_SLOTS*CHAR_W];
            load_run.len   = run_len_t'(5'(hi4_reg.len) + 5'(lo4_reg.len));
            load_run.err   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= item_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // Payload advances with its stage enable, holds otherwise
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            err1_reg  <= err1_next;
            thou1_reg <= thou1_next;
            rem1_reg  <= rem1_next;
        end
        if (en2)
        begin
            err2_reg  <= err1_reg;
            thou2_reg <= thou1_reg;
            hund2_reg <= hund2_next;
            rem2_reg  <= rem2_next;
        end
        if (en3)
        begin
            err3_reg  <= err2_reg;
            thou3_reg <= thou2_reg;
            hund3_reg <= hund2_reg;
            tens3_reg <= tens3_next;
            ones3_reg <= ones3_next;
        end
        if (en4)
        begin
            err4_reg <= err3_reg;
            hi4_reg  <= hi4_next;
            lo4_reg  <= lo4_next;
        end
    end

    i2r_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (v4_reg),
        .load_ready  (load_ready),
        .load_run    (load_run),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .symbol_char (symbol_char),
        .last_char   (last_char),
        .range_error (range_error)
    );

    a_rem1_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !err1_reg |-> rem1_reg < 10'd1000)
        else $error("thousands remainder out of range");

    a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !err3_reg |-> hund3_reg <= 4'd9 && tens3_reg <= 4'd9 && ones3_reg <= 4'd9)
        else $error("decimal digit out of range");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !err4_reg |-> (5'(hi4_reg.len) + 5'(lo4_reg.len)) <= 5'd15
                             && (5'(hi4_reg.len) + 5'(lo4_reg.len)) != 5'd0)
        else $error("numeral length out of range");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("input stalled with a free pipeline stage");

endmodule

// ===== sv/i2r_emit.sv =====
// ----------------------------------------------------------------------------
// i2r_emit: character emitter
// Holds one packed run of numeral characters and sends one beat per cycle
// unless stalled, marking the final beat; the next run loads as it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2r_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load_valid,
    output logic           load_ready,
    input  i2r_pkg::run_t  load_run,
    output logic           char_valid,
    input  logic           char_stall,
    output i2r_pkg::char_t symbol_char,
    output logic           last_char,
    output logic           range_error
);
    import i2r_pkg::*;

    logic       busy_reg, busy_next;
    run_len_t   left_reg, left_next;
    run_chars_t chars_reg, chars_next;
    logic       err_reg, err_next;
    logic       pop;

    assign pop         = busy_reg && !char_stall;
    assign last_char   = (left_reg == run_len_t'(1));
    assign load_ready  = !busy_reg || (pop && last_char);
    assign char_valid  = busy_reg;
    assign symbol_char = chars_reg[RUN_SLOTS*CHAR_W-1 -: CHAR_W];
    assign range_error = err_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        left_next  = left_reg;
        chars_next = chars_reg;
        err_next   = err_reg;
        if (load_ready)
        begin
            busy_next  = load_valid;
            left_next  = load_run.len;
            chars_next = load_run.chars;
            err_next   = load_run.err;
        end
        else if (pop)
        begin
            // advance to the next character
            left_next  = left_reg - run_len_t'(1);
            chars_next = chars_reg << CHAR_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
        err_reg   <= err_next;
    end

    a_busy_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> left_reg != '0)
        else $error("emitter busy with empty run");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && range_error |-> last_char && symbol_char == CH_NUL)
        else $error("error beat is not a single NUL character");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && !last_char |=> char_valid)
        else $error("run ended before its last beat");

    a_valid_letter: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !range_error |-> symbol_char != CH_NUL)
        else $error("NUL character inside a valid numeral");

endmodule

// ===== tb/roman_checker.sv =====
// ----------------------------------------------------------------------------
// roman_checker: scoreboard for the integer to Roman numeral block
// Watches the value and character channels. Every accepted value is expanded
// into the characters it should produce, and every accepted character beat is
// compared field by field with the oldest of those.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roman_checker
    import i2r_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    input  logic   item_stall,
    input  value_t value,
    input  logic   char_valid,
    input  logic   char_stall,
    input  char_t  symbol_char,
    input  logic   last_char,
    input  logic   range_error,
    output int     mismatches,
    output int     pending,
    output int     chars_checked
);

    localparam int NUM_WEIGHTS = 13;

    typedef struct {
        char_t symbol;
        logic  last;
        logic  err;
    } char_beat_t;

    localparam int unsigned WEIGHTS [NUM_WEIGHTS] =
        '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    localparam char_t LEAD_GLYPH [NUM_WEIGHTS] =
        '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
    // CH_NUL means the weight is written with a single letter
    localparam char_t TRAIL_GLYPH [NUM_WEIGHTS] =
        '{CH_NUL, CH_M, CH_NUL, CH_D, CH_NUL, CH_C, CH_NUL, CH_L, CH_NUL, CH_X,
          CH_NUL, CH_V, CH_NUL};

    char_beat_t expected_chars [$];
    int         error_count = 0;
    int         beat_count  = 0;

    initial
    begin
        mismatches    = 0;
        pending       = 0;
        chars_checked = 0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Greedy subtraction: emit the largest weight that still fits.
    task automatic push_numeral(input value_t v);
        int unsigned rest;
        char_t       run [RUN_SLOTS];
        int          count;
        char_beat_t  beat;
        rest  = v;
        count = 0;
        if (v == '0 || v > MAX_VALUE)
        begin
            beat.symbol = CH_NUL;
            beat.last   = 1'b1;
            beat.err    = 1'b1;
            expected_chars.push_back(beat);
            return;
        end
        for (int w = 0; w < NUM_WEIGHTS; w++)
        begin
            while (rest >= WEIGHTS[w] && count < RUN_SLOTS)
            begin
                rest -= WEIGHTS[w];
                run[count] = LEAD_GLYPH[w];
                count++;
                if (TRAIL_GLYPH[w] != CH_NUL && count < RUN_SLOTS)
                begin
                    run[count] = TRAIL_GLYPH[w];
                    count++;
                end
            end
        end
        for (int k = 0; k < count; k++)
        begin
            beat.symbol = run[k];
            beat.last   = (k == count - 1);
            beat.err    = 1'b0;
            expected_chars.push_back(beat);
        end
    endtask

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                push_numeral(value);
            if (char_valid && !char_stall)
            begin
                beat_count++;
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected character beat 0x%02h last=%b err=%b",
                                              symbol_char, last_char, range_error));
                else
                begin
                    want = expected_chars.pop_front();
                    if (symbol_char !== want.symbol)
                        report_mismatch($sformatf("symbol_char got 0x%02h want 0x%02h",
                                                  symbol_char, want.symbol));
                    if (last_char !== want.last)
                        report_mismatch($sformatf("last_char got %b want %b on 0x%02h",
                                                  last_char, want.last, want.symbol));
                    if (range_error !== want.err)
                        report_mismatch($sformatf("range_error got %b want %b on 0x%02h",
                                                  range_error, want.err, want.symbol));
                end
            end
        end
        mismatches    <= error_count;
        pending       <= expected_chars.size();
        chars_checked <= beat_count;
    end

endmodule

// ===== tb/integer_to_roman_numeral_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_tb: top level bench for the Roman numeral block
// Sends a directed set of values followed by random ones, with random gaps
// on the value side and random stalls on the character side, and leaves all
// checking to roman_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_roman_numeral_tb;

    import i2r_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 30;
    localparam int NUM_DIRECTED = 24;

    localparam value_t DIRECTED [NUM_DIRECTED] = '{
        12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd9, 12'd10, 12'd14,
        12'd40, 12'd49, 12'd90, 12'd400, 12'd444, 12'd900, 12'd1000, 12'd1444,
        12'd1994, 12'd2048, 12'd3888, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3
    };

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   item_valid  = 1'b0;
    logic   item_stall;
    value_t value       = '0;
    logic   char_valid;
    logic   char_stall  = 1'b0;
    char_t  symbol_char;
    logic   last_char;
    logic   range_error;

    int     mismatches;
    int     pending;
    int     chars_checked;
    int     values_sent   = 0;
    int     rejects_sent  = 0;
    int     send_quiet_left = 0;
    logic   send_quiet    = 1'b0;

    integer_to_roman_numeral u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .value       (value),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .symbol_char (symbol_char),
        .last_char   (last_char),
        .range_error (range_error)
    );

    roman_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .value         (value),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .symbol_char   (symbol_char),
        .last_char     (last_char),
        .range_error   (range_error),
        .mismatches    (mismatches),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Idle a random number of cycles, then hold the beat until it is taken.
    task automatic send_value(input value_t v);
        int gap;
        if (send_quiet_left == 0)
        begin
            send_quiet      = ($urandom_range(0, 3) == 0);
            send_quiet_left = $urandom_range(10, 40);
        end
        send_quiet_left--;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        do @(posedge clk); while (item_stall);
        values_sent++;
        if (v == '0 || v > MAX_VALUE)
            rejects_sent++;
    endtask

    function automatic value_t draw_value();
        int kind;
        kind = $urandom_range(0, 19);
        case (kind)
            0:       return '0;
            1, 2:    return value_t'($urandom_range(4000, 4095));
            3:       return value_t'($urandom);
            default: return value_t'($urandom_range(1, 3999));
        endcase
    endfunction

    // Character side: stall a random number of cycles ahead of every beat.
    initial
    begin
        int  hold;
        int  quiet_left;
        logic quiet;
        quiet_left = 0;
        quiet      = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet_left == 0)
            begin
                quiet      = ($urandom_range(0, 3) == 0);
                quiet_left = $urandom_range(10, 60);
            end
            quiet_left--;
            hold = quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                char_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            char_stall <= 1'b0;
            do @(posedge clk); while (!char_valid);
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d characters still outstanding",
                 CYCLE_LIMIT, pending);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(DIRECTED[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_value(draw_value());
        item_valid <= 1'b0;
        // let the checker register the last value before polling it
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d values (%0d out of range) with random gaps and stalls,",
                 values_sent, rejects_sent);
        $display("checked %0d numeral characters", chars_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
